FILE: hdl/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Shared constants, the hue segment code and the percent-to-byte table.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  // Default number of fraction bits of the internal fixed-point format.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Percent levels run from 0 to 100 and fit in seven bits.
  localparam int unsigned PCT_W   = 7;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Which piece of the hue ramp a channel falls on.
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  typedef logic [7:0] byte_lut_t [2**PCT_W];

  // Percent to byte, rounding half up: floor(pc * 255 / 100 + 1/2).
  function automatic byte_lut_t build_byte_lut();
    byte_lut_t lut;
    for (int i = 0; i < 2**PCT_W; i++) begin
      lut[i] = 8'((i * 510 + 100) / 200);
    end
    return lut;
  endfunction

  localparam byte_lut_t BYTE_LUT = build_byte_lut();

endpackage

FILE: hdl/hsl2rgb_front.sv
// ----------------------------------------------------------------------------
// HSL to RGB front end
// Four stages: rescale and hue offsets, L*S product, high level and ramp
// segment per channel, low level and span.
// ----------------------------------------------------------------------------
module hsl2rgb_front #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       hue,
  input  logic [16:0]                       saturation,
  input  logic [16:0]                       lightness,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_zero,
  output logic [FRAC_BITS:0]                out_light,
  output logic [FRAC_BITS:0]                out_hi,
  output logic [FRAC_BITS:0]                out_lo,
  output logic [FRAC_BITS:0]                out_span,
  output logic [2:0][FRAC_BITS:0]           out_factor,
  output hsl2rgb_pkg::seg_t [2:0]           out_seg
);

  localparam int unsigned HW = FRAC_BITS;
  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned T3 = FRAC_BITS + 3;
  localparam int unsigned W2 = FRAC_BITS + 2;
  localparam logic [W-1:0]  ONE      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0]  HALF     = ONE >> 1;
  localparam logic [HW-1:0] THIRD    = HW'((64'd1 << FRAC_BITS) / 3);
  localparam logic [T3-1:0] ONE_T3   = T3'(ONE);
  localparam logic [T3-1:0] FOUR_ONE = T3'(ONE) << 2;

  // Handshake: a stage moves on when it is empty or the next one moves.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt;
  logic adv1, adv2, adv3, adv4;

  assign adv4     = !s4_v_r || out_ready;
  assign adv3     = !s3_v_r || adv4;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  assign s1_v_nxt = adv1 ? in_valid : s1_v_r;
  assign s2_v_nxt = adv2 ? s1_v_r   : s2_v_r;
  assign s3_v_nxt = adv3 ? s2_v_r   : s3_v_r;
  assign s4_v_nxt = adv4 ? s3_v_r   : s4_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      s4_v_r <= s4_v_nxt;
    end
  end

  // Stage 1: rescale to the internal format and clamp to one.
  logic [HW-1:0] h_sc;
  logic [W-1:0]  s_sc, l_sc;

  generate
    if (FRAC_BITS >= 16) begin : g_up
      assign h_sc = HW'(hue) << (FRAC_BITS - 16);
      assign s_sc = W'(saturation) << (FRAC_BITS - 16);
      assign l_sc = W'(lightness) << (FRAC_BITS - 16);
    end else begin : g_dn
      assign h_sc = hue[15 -: HW];
      assign s_sc = saturation[16 -: W];
      assign l_sc = lightness[16 -: W];
    end
  endgenerate

  logic [2:0][HW-1:0] s1_t_r;
  logic [W-1:0]       s1_s_r, s1_l_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_t_r[0] <= h_sc + THIRD;
      s1_t_r[1] <= h_sc;
      s1_t_r[2] <= h_sc - THIRD;
      s1_s_r    <= (s_sc > ONE) ? ONE : s_sc;
      s1_l_r    <= (l_sc > ONE) ? ONE : l_sc;
    end
  end

  // Stage 2: L*S with the fraction bits dropped.
  logic [PW-1:0]      prod_ls;
  logic [2:0][HW-1:0] s2_t_r;
  logic [W-1:0]       s2_s_r, s2_l_r, s2_ls_r;

  assign prod_ls = PW'(s1_l_r) * PW'(s1_s_r);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_t_r  <= s1_t_r;
      s2_s_r  <= s1_s_r;
      s2_l_r  <= s1_l_r;
      s2_ls_r <= prod_ls[FRAC_BITS +: W];
    end
  end

  // Stage 3: high level and the ramp segment and factor of each channel.
  logic [W2-1:0]          hi_raw;
  logic [W-1:0]           hi_cl;
  logic [2:0][T3-1:0]     six_t;
  logic [2:0][T3-1:0]     fall_t;
  logic [2:0][W-1:0]      factor;
  hsl2rgb_pkg::seg_t [2:0] seg;

  always_comb begin
    if (s2_l_r < HALF) begin
      hi_raw = W2'(s2_l_r) + W2'(s2_ls_r);
    end else begin
      hi_raw = W2'(s2_l_r) + W2'(s2_s_r) - W2'(s2_ls_r);
    end
    hi_cl = (hi_raw > W2'(ONE)) ? ONE : hi_raw[W-1:0];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      six_t[c]  = (T3'(s2_t_r[c]) << 2) + (T3'(s2_t_r[c]) << 1);
      fall_t[c] = FOUR_ONE - six_t[c];
      if (six_t[c] < ONE_T3) begin
        seg[c]    = hsl2rgb_pkg::SEG_RISE;
        factor[c] = six_t[c][W-1:0];
      end else if (!s2_t_r[c][HW-1]) begin
        seg[c]    = hsl2rgb_pkg::SEG_HIGH;
        factor[c] = '0;
      end else if (six_t[c] < FOUR_ONE) begin
        seg[c]    = hsl2rgb_pkg::SEG_FALL;
        factor[c] = fall_t[c][W-1:0];
      end else begin
        seg[c]    = hsl2rgb_pkg::SEG_LOW;
        factor[c] = '0;
      end
    end
  end

  logic                    s3_zero_r;
  logic [W-1:0]            s3_l_r, s3_hi_r;
  logic [2:0][W-1:0]       s3_factor_r;
  hsl2rgb_pkg::seg_t [2:0] s3_seg_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_zero_r   <= (s2_s_r == '0);
      s3_l_r      <= s2_l_r;
      s3_hi_r     <= hi_cl;
      s3_factor_r <= factor;
      s3_seg_r    <= seg;
    end
  end

  // Stage 4: low level 2L - hi, kept between zero and hi, and the span.
  logic [W2-1:0] l2;
  logic [W2-1:0] lo_raw;
  logic [W-1:0]  lo_cl;

  always_comb begin
    l2     = {s3_l_r, 1'b0};
    lo_raw = (l2 > W2'(s3_hi_r)) ? (l2 - W2'(s3_hi_r)) : '0;
    lo_cl  = (lo_raw > W2'(s3_hi_r)) ? s3_hi_r : lo_raw[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_zero   <= s3_zero_r;
      out_light  <= s3_l_r;
      out_hi     <= s3_hi_r;
      out_lo     <= lo_cl;
      out_span   <= s3_hi_r - lo_cl;
      out_factor <= s3_factor_r;
      out_seg    <= s3_seg_r;
    end
  end

  assign out_valid = s4_v_r;

endmodule

FILE: hdl/hsl2rgb_ramp.sv
// ----------------------------------------------------------------------------
// HSL to RGB ramp stage
// One stage: evaluates the hue ramp of each channel from span times factor.
// ----------------------------------------------------------------------------
module hsl2rgb_ramp #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_zero,
  input  logic [FRAC_BITS:0]      in_light,
  input  logic [FRAC_BITS:0]      in_hi,
  input  logic [FRAC_BITS:0]      in_lo,
  input  logic [FRAC_BITS:0]      in_span,
  input  logic [2:0][FRAC_BITS:0] in_factor,
  input  hsl2rgb_pkg::seg_t [2:0] in_seg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0][FRAC_BITS:0] out_level
);

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * W;

  logic v_r, v_nxt, adv;

  assign adv      = !v_r || out_ready;
  assign in_ready = adv;
  assign v_nxt    = adv ? in_valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  logic [2:0][PW-1:0] prod;
  logic [2:0][W-1:0]  level;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PW'(in_span) * PW'(in_factor[c]);
      case (in_seg[c]) inside
        hsl2rgb_pkg::SEG_RISE,
        hsl2rgb_pkg::SEG_FALL: level[c] = in_lo + prod[c][FRAC_BITS +: W];
        hsl2rgb_pkg::SEG_HIGH: level[c] = in_hi;
        default:               level[c] = in_lo;
      endcase
      // With no saturation every channel is the lightness itself.
      if (in_zero) begin
        level[c] = in_light;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_level <= level;
    end
  end

  assign out_valid = v_r;

endmodule

FILE: hdl/hsl2rgb_quant.sv
// ----------------------------------------------------------------------------
// HSL to RGB quantizer
// Two stages: level to truncated percent, then percent to a rounded byte.
// ----------------------------------------------------------------------------
module hsl2rgb_quant #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0][FRAC_BITS:0] in_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [23:0]             out_rgb
);

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned MW = W + 7;

  logic s1_v_r, s2_v_r, s1_v_nxt, s2_v_nxt, adv1, adv2;

  assign adv2     = !s2_v_r || out_ready;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;
  assign s1_v_nxt = adv1 ? in_valid : s1_v_r;
  assign s2_v_nxt = adv2 ? s1_v_r   : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Level times 100 as shifts and adds, then the fraction bits dropped.
  logic [2:0][MW-1:0] times100;
  logic [2:0][7:0]    pct_raw;
  logic [2:0][hsl2rgb_pkg::PCT_W-1:0] pct;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      times100[c] = (MW'(in_level[c]) << 6) + (MW'(in_level[c]) << 5)
                  + (MW'(in_level[c]) << 2);
      pct_raw[c]  = times100[c][FRAC_BITS +: 8];
      pct[c]      = (pct_raw[c] > 8'(hsl2rgb_pkg::PCT_MAX)) ? hsl2rgb_pkg::PCT_MAX
                                                            : pct_raw[c][6:0];
    end
  end

  logic [2:0][hsl2rgb_pkg::PCT_W-1:0] s1_pct_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_pct_r <= pct;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_rgb <= {hsl2rgb_pkg::BYTE_LUT[s1_pct_r[2]],
                  hsl2rgb_pkg::BYTE_LUT[s1_pct_r[1]],
                  hsl2rgb_pkg::BYTE_LUT[s1_pct_r[0]]};
    end
  end

  assign out_valid = s2_v_r;

endmodule

FILE: hdl/hsl_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Streaming conversion of hue, saturation and lightness to 8-bit RGB.
// ----------------------------------------------------------------------------
// The converter takes one request per clock while the output side does not
// stall and returns one RGB result per request, in the order of the requests.
// The path is a seven-stage pipeline: four stages prepare the
// levels (input rescale, the L*S multiplier, the high level with the hue
// segment of each channel, the low level and span), one stage runs the three
// ramp multipliers, and two stages turn each level into a percent and then
// into a rounded byte. Every stage carries its own valid bit and holds while
// the stage after it is full and stalled, so empty stages keep filling
// behind a stalled output and nothing is dropped or repeated. Hue is a
// fraction of a turn scaled by 65536; saturation and lightness are scaled the
// same way and may be exactly 65536 (values above that count as one).
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_top #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // hue[15:0], saturation[32:16], lightness[49:33]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  // Front end to ramp stage.
  logic                    front_valid, front_ready, front_zero;
  logic [FRAC_BITS:0]      front_light, front_hi, front_lo, front_span;
  logic [2:0][FRAC_BITS:0] front_factor;
  hsl2rgb_pkg::seg_t [2:0] front_seg;

  // Ramp stage to quantizer.
  logic                    ramp_valid, ramp_ready;
  logic [2:0][FRAC_BITS:0] ramp_level;

  hsl2rgb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .hue        (in_tdata[15:0]),
    .saturation (in_tdata[32:16]),
    .lightness  (in_tdata[49:33]),
    .out_valid  (front_valid),
    .out_ready  (front_ready),
    .out_zero   (front_zero),
    .out_light  (front_light),
    .out_hi     (front_hi),
    .out_lo     (front_lo),
    .out_span   (front_span),
    .out_factor (front_factor),
    .out_seg    (front_seg)
  );

  hsl2rgb_ramp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_zero   (front_zero),
    .in_light  (front_light),
    .in_hi     (front_hi),
    .in_lo     (front_lo),
    .in_span   (front_span),
    .in_factor (front_factor),
    .in_seg    (front_seg),
    .out_valid (ramp_valid),
    .out_ready (ramp_ready),
    .out_level (ramp_level)
  );

  // The quantizer's last stage is the output register of the block.
  hsl2rgb_quant #(
    .FRAC_BITS (FRAC_BITS)
  ) u_quant (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ramp_valid),
    .in_ready  (ramp_ready),
    .in_level  (ramp_level),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rgb   (out_tdata)
  );

  // The input can only be held off when the whole pipeline is backed up
  // behind a stalled output.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the output side was free");

  // A ramp result appears only when the front end offered one.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ramp_valid) |-> $past(front_valid))
    else $error("ramp stage became valid without a request from the front end");

  // A ramp result held back by the quantizer keeps its levels.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ramp_valid && !ramp_ready) |=> (ramp_valid && $stable(ramp_level)))
    else $error("stalled ramp result changed or vanished");

endmodule
